>>> sv/utf8_validity_checker_core_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 validity checker assertion macros
// Shared property wrappers for the block's checker
// ----------------------------------------------------------------------------
`ifndef UTF8_VALIDITY_CHECKER_CORE_ASSERT_SVH
`define UTF8_VALIDITY_CHECKER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define UVC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8 checker: implication failed");

// next-cycle implication, disabled during reset
`define UVC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8 checker: next-cycle implication failed");

// next-cycle implication that also holds through reset
`define UVC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("utf8 checker: reset behavior failed");

`endif

>>> sv/utf8vc_pkg.sv
// ----------------------------------------------------------------------------
// utf8vc_pkg
// Byte classes, DFA transition table, NUL modes and step result type
// ----------------------------------------------------------------------------
package utf8vc_pkg;

  // dfa states
  localparam logic [3:0] ST_ACCEPT  = 4'd0;
  localparam logic [3:0] ST_REJECT  = 4'd1;
  localparam logic [3:0] ST_LAST_IX = 4'd8;

  // nul handling modes
  typedef enum logic [1:0] {
    NUL_TERMINATE = 2'd0,
    NUL_DATA      = 2'd1,
    NUL_FORBID    = 2'd2,
    NUL_UNUSED    = 2'd3
  } nul_mode_t;

  // transition table, rows by state, columns by byte class
  localparam logic [3:0] NEXT_TBL [9][16] = '{
    '{4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1}
  };

  // outcome of one byte step
  typedef struct packed {
    logic [3:0] state_next;
    logic       skip_next;
    logic       res_en;
    logic       valid_res;
    logic       ended_by_nul;
  } step_res_t;

  // map a byte to its character class
  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] cls;
    case (b) inside
      [8'h00:8'h7F]: cls = 4'd0;
      [8'h80:8'h8F]: cls = 4'd1;
      [8'h90:8'h9F]: cls = 4'd9;
      [8'hA0:8'hBF]: cls = 4'd7;
      [8'hC0:8'hC1]: cls = 4'd8;
      [8'hC2:8'hDF]: cls = 4'd2;
      8'hE0:         cls = 4'd10;
      8'hED:         cls = 4'd4;
      [8'hE1:8'hEF]: cls = 4'd3;
      8'hF0:         cls = 4'd11;
      [8'hF1:8'hF3]: cls = 4'd6;
      8'hF4:         cls = 4'd5;
      default:       cls = 4'd8;
    endcase
    return cls;
  endfunction

endpackage

>>> sv/utf8vc_step.sv
// ----------------------------------------------------------------------------
// utf8vc_step
// One byte of the validator: NUL handling, DFA transition and frame result
// ----------------------------------------------------------------------------
module utf8vc_step (
  input  logic [3:0]              state,
  input  logic                    skip,
  input  utf8vc_pkg::nul_mode_t   mode,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output utf8vc_pkg::step_res_t   res
);
  import utf8vc_pkg::*;

  logic [3:0] cls;
  logic [3:0] dfa_next;
  logic       nul_ends;

  // class lookup and transition, unreachable codes act as reject
  assign cls = byte_class(data_byte);

  always_comb begin
    if (state > ST_LAST_IX) begin
      dfa_next = ST_REJECT;
    end else begin
      dfa_next = NEXT_TBL[state][cls];
    end
  end

  assign nul_ends = (data_byte == 8'h00) && ((mode == NUL_TERMINATE) || (mode == NUL_FORBID));

  // pick the outcome for this byte
  always_comb begin
    res.state_next   = state;
    res.skip_next    = skip;
    res.res_en       = 1'b0;
    res.valid_res    = 1'b0;
    res.ended_by_nul = 1'b0;
    if (skip) begin
      // discarding the tail of a frame that a NUL already ended
      if (last_byte) begin
        res.skip_next  = 1'b0;
        res.state_next = ST_ACCEPT;
      end
    end else if (nul_ends) begin
      res.res_en       = 1'b1;
      res.valid_res    = (mode == NUL_TERMINATE) && (state == ST_ACCEPT);
      res.ended_by_nul = 1'b1;
      res.state_next   = ST_ACCEPT;
      res.skip_next    = !last_byte;
    end else if (last_byte) begin
      res.res_en     = 1'b1;
      res.valid_res  = (dfa_next == ST_ACCEPT);
      res.state_next = ST_ACCEPT;
    end else begin
      res.state_next = dfa_next;
    end
  end

endmodule

>>> sv/utf8_validity_checker_core.sv
// ----------------------------------------------------------------------------
// utf8_validity_checker_core
// Streaming UTF-8 frame validator with configurable NUL handling
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata[7:0] data_byte, tlast last_byte
//  m_axis    | out       | tdata[0] valid_res, tuser ended_by_nul
//  cfg       | in        | cfg_wr_data nul_handling (0 end, 1 data, 2 forbid)
//
//  one byte per cycle while m_axis is not stalled; a byte is registered in the
//  input register, then its frame result in the output register
//  the DFA state update through the class/transition table sets the cycle
//  rst is synchronous; it empties both registers and restores NUL data mode
//  an output stall holds one result and one byte, then drops s_axis_tready
// ----------------------------------------------------------------------------
module utf8_validity_checker_core (
  input  logic       clk,
  input  logic       rst,
  // input bytes
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,
  // frame results
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] valid_res, [7:1] zero
  output logic       m_axis_tuser,   // [0] ended_by_nul
  // configuration
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);
  import utf8vc_pkg::*;

  nul_mode_t  nul_handling;
  logic [3:0] dfa_state;
  logic       skip_rest;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  logic       res_valid;
  logic       res_ok;
  logic       res_nul;

  logic       out_free;
  logic       step_fire;
  step_res_t  step;

  // output register can take a new result
  assign out_free      = !res_valid || m_axis_tready;
  assign step_fire     = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      nul_handling <= NUL_DATA;
    end else if (cfg_wr_en) begin
      nul_handling <= nul_mode_t'(cfg_wr_data);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // per-byte step logic
  utf8vc_step u_step (
    .state     (dfa_state),
    .skip      (skip_rest),
    .mode      (nul_handling),
    .data_byte (in_byte),
    .last_byte (in_last),
    .res       (step)
  );

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      dfa_state <= ST_ACCEPT;
      skip_rest <= 1'b0;
    end else if (step_fire) begin
      dfa_state <= step.state_next;
      skip_rest <= step.skip_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= step_fire && step.res_en;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && step.res_en) begin
      res_ok  <= step.valid_res;
      res_nul <= step.ended_by_nul;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {7'b0, res_ok};
  assign m_axis_tuser  = res_nul;

endmodule

>>> sv/utf8vc_checker.sv
// ----------------------------------------------------------------------------
// utf8vc_checker
// Port-level checks for the UTF-8 validity checker, bound to the top level
// ----------------------------------------------------------------------------
`include "utf8_validity_checker_core_assert.svh"

module utf8vc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser
);

  // a stalled result keeps its payload
  `UVC_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // no result is offered right after reset
  `UVC_ASSERT_NXT_ALWAYS(a_rst_empty, clk, rst, !m_axis_tvalid)

  // with the output empty the input side never backpressures
  `UVC_ASSERT_IMP(a_in_ready, clk, rst, !m_axis_tvalid, s_axis_tready)

  // result padding bits stay zero
  `UVC_ASSERT_IMP(a_pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[7:1] == 7'b0)

endmodule

bind utf8_validity_checker_core utf8vc_checker u_utf8vc_checker (.*);

>>> test/utf8_validity_checker_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_validity_checker_core_test
// Streams byte frames into the checker under every NUL mode and compares
// each frame verdict with a cycle-free DFA predictor kept in the bench
// ----------------------------------------------------------------------------
module utf8_validity_checker_core_test;
  import utf8vc_pkg::*;

  // one byte transfer as queued for the driver
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_byte_t;

  // one expected frame verdict
  typedef struct packed {
    logic valid_res;
    logic ended_by_nul;
  } frame_verdict_t;

  // transitions, rows by dfa state, columns by byte class
  localparam logic [3:0] DFA_NEXT [9][16] = '{
    '{4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1}
  };

  localparam int RAND_ITEMS = 1900;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;   // [7:0] data_byte
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [0] valid_res, [7:1] zero
  logic       m_axis_tuser;          // [0] ended_by_nul
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = 2'd0;

  // predictor state
  nul_mode_t  nul_mode = NUL_DATA;
  logic [3:0] dfa_st = ST_ACCEPT;
  logic       skipping = 1'b0;

  in_byte_t       byte_q [$];
  frame_verdict_t verdict_q [$];
  logic [7:0]     frame_buf [$];

  int          bytes_queued = 0;
  int          bytes_taken = 0;
  int          errors = 0;
  logic        in_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int unsigned rx_cycle = 0;
  int          stall_left = 0;

  utf8_validity_checker_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // character class of one byte
  function automatic logic [3:0] utf8_class(input logic [7:0] b);
    if (b < 8'h80) return 4'd0;
    if (b < 8'h90) return 4'd1;
    if (b < 8'hA0) return 4'd9;
    if (b < 8'hC0) return 4'd7;
    if (b < 8'hC2) return 4'd8;
    if (b < 8'hE0) return 4'd2;
    if (b == 8'hE0) return 4'd10;
    if (b == 8'hED) return 4'd4;
    if (b < 8'hF0) return 4'd3;
    if (b == 8'hF0) return 4'd11;
    if (b < 8'hF4) return 4'd6;
    if (b == 8'hF4) return 4'd5;
    return 4'd8;
  endfunction

  // advance the frame dfa by one accepted byte, queue a verdict if it ends a frame
  task automatic step_utf8_dfa(input logic [7:0] b, input logic last);
    logic [3:0]     cur;
    frame_verdict_t v;
    // bytes after an early NUL end are dropped up to the frame end
    if (skipping) begin
      if (last) begin
        skipping = 1'b0;
        dfa_st = ST_ACCEPT;
      end
      return;
    end
    if (b == 8'h00 && (nul_mode == NUL_TERMINATE || nul_mode == NUL_FORBID)) begin
      v.valid_res = (nul_mode == NUL_TERMINATE) && (dfa_st == ST_ACCEPT);
      v.ended_by_nul = 1'b1;
      verdict_q.push_back(v);
      dfa_st = ST_ACCEPT;
      skipping = !last;
      return;
    end
    cur = (dfa_st > 4'd8) ? ST_REJECT : dfa_st;
    dfa_st = DFA_NEXT[cur][utf8_class(b)];
    if (last) begin
      v.valid_res = (dfa_st == ST_ACCEPT);
      v.ended_by_nul = 1'b0;
      verdict_q.push_back(v);
      dfa_st = ST_ACCEPT;
    end
  endtask

  // input side: bursts of transfers with random gaps
  always @(negedge clk) begin
    in_byte_t item;
    if (!rst && (!s_axis_tvalid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        item = byte_q.pop_front();
        s_axis_tdata  <= item.data;
        s_axis_tlast  <= item.last;
        s_axis_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side: ready pattern rotates among always ready, random, stall bursts and periodic drops
  always @(negedge clk) begin
    rx_cycle++;
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_cycle >> 8) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 1);
        2: begin
          if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 16);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
        default: m_axis_tready <= (rx_cycle % 5 != 0);
      endcase
    end
  end

  // monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin
    frame_verdict_t want;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        step_utf8_dfa(s_axis_tdata, s_axis_tlast);
        bytes_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got tdata=%h tuser=%b",
                   $time, m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata !== {7'd0, want.valid_res}) begin
            $display("%0t: valid_res mismatch, expected tdata=%h, got tdata=%h",
                     $time, {7'd0, want.valid_res}, m_axis_tdata);
            errors++;
          end
          if (m_axis_tuser !== want.ended_by_nul) begin
            $display("%0t: ended_by_nul mismatch, expected %b, got %b",
                     $time, want.ended_by_nul, m_axis_tuser);
            errors++;
          end
        end
      end
    end
  end

  // queue the frame buffer for the driver, last mark optional
  task automatic send_frame(input logic with_last);
    in_byte_t item;
    for (int i = 0; i < frame_buf.size(); i++) begin
      item.data = frame_buf[i];
      item.last = with_last && (i == frame_buf.size() - 1);
      byte_q.push_back(item);
    end
    bytes_queued += frame_buf.size();
    frame_buf.delete();
  endtask

  // append one well-formed character of random length
  task automatic add_char();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: begin
        if ($urandom_range(0, 15) == 0) frame_buf.push_back(8'h00);
        else frame_buf.push_back(8'($urandom_range(8'h00, 8'h7F)));
      end
      4: begin
        frame_buf.push_back(8'($urandom_range(8'hC2, 8'hDF)));
        frame_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
      5: begin
        frame_buf.push_back(8'hE0);
        frame_buf.push_back(8'($urandom_range(8'hA0, 8'hBF)));
        frame_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
      6: begin
        frame_buf.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'hEE, 8'hEF))
                                                      : 8'($urandom_range(8'hE1, 8'hEC)));
        frame_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
        frame_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
      7: begin
        frame_buf.push_back(8'hED);
        frame_buf.push_back(8'($urandom_range(8'h80, 8'h9F)));
        frame_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
      8: begin
        frame_buf.push_back(8'hF0);
        frame_buf.push_back(8'($urandom_range(8'h90, 8'hBF)));
        frame_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
        frame_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          frame_buf.push_back(8'($urandom_range(8'hF1, 8'hF3)));
          frame_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else begin
          frame_buf.push_back(8'hF4);
          frame_buf.push_back(8'($urandom_range(8'h80, 8'h8F)));
        end
        frame_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
        frame_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
    endcase
  endtask

  // mostly well-formed frames, some corrupted, truncated, noise or NUL-split
  task automatic build_random_frame();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    n = $urandom_range(1, 6);
    if (kind == 8) begin
      repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (n) add_char();
      if (kind == 9) begin
        frame_buf.push_back(8'h00);
        n = $urandom_range(0, 3);
        repeat (n) add_char();
      end
      if (kind == 6) frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom_range(0, 255));
      if (kind == 7 && frame_buf.size() > 1) void'(frame_buf.pop_back());
    end
  endtask

  // hold off until every byte is taken and every verdict has come out
  task automatic wait_idle();
    do @(negedge clk);
    while (bytes_taken != bytes_queued || verdict_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // mode register write while the block is idle
  task automatic write_mode(input nul_mode_t m);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    nul_mode = m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // stimulus
  initial begin
    int        phase_ix;
    int        phase_end;
    nul_mode_t m;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset mode: NUL is data, frames that together cover every byte class
    frame_buf = '{8'h00, 8'h7F};             send_frame(1'b1);
    frame_buf = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_frame(1'b1);
    frame_buf = '{8'hED, 8'hA0};             send_frame(1'b1);
    frame_buf = '{8'hC2, 8'h9F};             send_frame(1'b1);
    frame_buf = '{8'hE0, 8'hA0};             send_frame(1'b1);
    frame_buf = '{8'hF0};                    send_frame(1'b1);
    frame_buf = '{8'hF3};                    send_frame(1'b1);
    frame_buf = '{8'hC1};                    send_frame(1'b1);
    frame_buf = '{8'hFF};                    send_frame(1'b1);
    frame_buf = '{8'hE5};                    send_frame(1'b1);

    // terminate mode: early NUL with discarded tail, NUL on last byte mid-sequence
    write_mode(NUL_TERMINATE);
    frame_buf = '{8'h41, 8'h00, 8'hC2};      send_frame(1'b1);
    frame_buf = '{8'hC2, 8'h00};             send_frame(1'b1);

    // forbid mode: NUL rejects the frame at once
    write_mode(NUL_FORBID);
    frame_buf = '{8'h41, 8'h00};             send_frame(1'b1);
    frame_buf = '{8'h00, 8'h80};             send_frame(1'b1);

    // unused mode behaves as data mode
    write_mode(NUL_UNUSED);
    frame_buf = '{8'h00};                    send_frame(1'b1);

    // random phases; a phase may end mid-frame so the next mode takes over
    phase_ix = 0;
    while (bytes_queued < RAND_ITEMS) begin
      case (phase_ix)
        0: m = NUL_TERMINATE;
        1: m = NUL_FORBID;
        2: m = NUL_UNUSED;
        3: m = NUL_DATA;
        default: m = nul_mode_t'($urandom_range(0, 3));
      endcase
      write_mode(m);
      phase_end = bytes_queued + $urandom_range(120, 260);
      while (bytes_queued < phase_end && bytes_queued < RAND_ITEMS) begin
        build_random_frame();
        if (bytes_queued + frame_buf.size() >= phase_end && $urandom_range(0, 2) == 0)
          send_frame(1'b0);
        else
          send_frame(1'b1);
      end
      phase_ix++;
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("utf8_validity_checker_core regression: pass");
    end else begin
      $display("utf8_validity_checker_core regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("utf8_validity_checker_core regression: fail");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/utf8vc_pkg.sv
sv/utf8vc_step.sv
sv/utf8_validity_checker_core.sv
sv/utf8vc_checker.sv
test/utf8_validity_checker_core_test.sv
